// ===== hdl/nmea_gga_position_parser_unit_assert.svh =====
// Assertion macros used by the checker file of the GGA position parser.
`ifndef NMEA_GGA_POSITION_PARSER_UNIT_ASSERT_SVH
`define NMEA_GGA_POSITION_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GGAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GGAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hdl/ggap_pkg.sv =====
// ============================================================================
// ggap_pkg
// Types and constants shared by the GGA position parser modules.
// ============================================================================
`default_nettype none

package ggap_pkg;

    localparam int INT_W  = 17;
    localparam int FRAC_W = 24;  // holds up to seven fraction digits
    localparam int FD_W   = 3;
    localparam int MAG_W  = 34;
    localparam int COORD_W = 35;

    localparam logic [INT_W-1:0] INT_ACC_MAX = 17'd131071;
    localparam logic [7:0]       QUAL_MAX    = 8'd255;
    localparam logic [3:0]       TOKEN_MAX   = 4'd15;
    localparam logic [2:0]       HDR_LEN     = 3'd7;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [1:0] PH_INT  = 2'd0;
    localparam logic [1:0] PH_FRAC = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [3:0] TOK_LAT     = 4'd2;
    localparam logic [3:0] TOK_LAT_HEM = 4'd3;
    localparam logic [3:0] TOK_LON     = 4'd4;
    localparam logic [3:0] TOK_LON_HEM = 4'd5;
    localparam logic [3:0] TOK_QUAL    = 4'd6;

    localparam logic            RK_LINE = 1'b0;
    localparam logic            RK_REQ  = 1'b1;

    // Reciprocal multipliers for the constant divisions.
    localparam logic [17:0] DIV100_MUL = 18'd167773;
    localparam int          DIV100_SH  = 24;
    localparam logic [28:0] DIV15_MUL  = 29'd286331154;
    localparam int          DIV15_SH   = 32;

    typedef struct packed {
        logic                valid;
        logic                is_lon;
        logic [INT_W-1:0]    int_part;
        logic [FRAC_W-1:0]   frac_part;
        logic [FD_W-1:0]     frac_digits;
    } coord_launch_t;

    typedef struct packed {
        logic                lat_ok;
        logic [MAG_W-1:0]    lat_mag;
        logic                lon_ok;
        logic [MAG_W-1:0]    lon_mag;
    } coord_result_t;

    typedef struct packed {
        logic                       valid;
        logic                       kind;
        logic                       accepted;
        logic                       fresh;
        logic                       fix;
        logic signed [COORD_W-1:0]  lat;
        logic signed [COORD_W-1:0]  lon;
    } line_result_t;

    function automatic logic [FRAC_W-1:0] pow10(input logic [FD_W-1:0] n);
        logic [FRAC_W-1:0] r;
        case (n)
            3'd0:    r = 24'd1;
            3'd1:    r = 24'd10;
            3'd2:    r = 24'd100;
            3'd3:    r = 24'd1000;
            3'd4:    r = 24'd10000;
            3'd5:    r = 24'd100000;
            3'd6:    r = 24'd1000000;
            default: r = 24'd10000000;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h24;  // '$'
            3'd1:    r = 8'h47;  // 'G'
            3'd2:    r = 8'h50;  // 'P'
            3'd3:    r = 8'h47;  // 'G'
            3'd4:    r = 8'h47;  // 'G'
            3'd5:    r = 8'h41;  // 'A'
            default: r = CH_COMMA;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ggap_coord_pipe.sv =====
// ============================================================================
// ggap_coord_pipe
// Four-stage pipeline that turns a ddmm.mmmm field into 1e-7 degree units.
// ============================================================================
`default_nettype none

module ggap_coord_pipe
    import ggap_pkg::*;
#(
    parameter int FRAC_DIGITS = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire coord_launch_t launch,
    input  wire logic          clr,
    output coord_result_t      result
);

    localparam logic [FD_W-1:0] FD_MAX = FD_W'(FRAC_DIGITS);
    localparam logic [FRAC_W-1:0] FS_SCALE = FRAC_W'(10 ** (7 - FRAC_DIGITS));
    localparam logic [29:0] MIN_SCALE = 30'd10000000;
    localparam logic [MAG_W-1:0] DEG_SCALE = 34'd10000000;

    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic s1_lon_reg, s2_lon_reg, s3_lon_reg;
    logic [INT_W-1:0]  s1_int_reg;
    logic [10:0]       s1_deg_reg;
    logic [FRAC_W-1:0] s1_fs_reg, s2_fs_reg;
    logic [6:0]        s2_mins_reg;
    logic [MAG_W-1:0]  s2_dege7_reg, s3_dege7_reg;
    logic [29:0]       s3_u_reg;
    logic              lat_ok_reg, lon_ok_reg;
    logic [MAG_W-1:0]  lat_mag_reg, lon_mag_reg;

    logic [34:0]       deg_prod;
    logic [47:0]       fs_prod;
    logic [INT_W-1:0]  mins_wide;
    logic [29:0]       u_next;
    logic [56:0]       q_prod;
    logic [MAG_W-1:0]  mag_next;

    assign deg_prod  = 35'(launch.int_part) * 35'(DIV100_MUL);
    assign fs_prod   = 48'(launch.frac_part) * 48'(pow10(FD_MAX - launch.frac_digits));
    assign mins_wide = s1_int_reg - (INT_W'(s1_deg_reg) * INT_W'(100));
    assign u_next    = (30'(s2_mins_reg) * MIN_SCALE) + 30'(s2_fs_reg * FS_SCALE);
    // floor(u/60) as floor((u/4)/15) by a rounded-up reciprocal.
    assign q_prod    = 57'(s3_u_reg[29:2]) * 57'(DIV15_MUL);
    assign mag_next  = s3_dege7_reg + MAG_W'(q_prod[56:DIV15_SH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            lat_ok_reg <= 1'b0;
            lon_ok_reg <= 1'b0;
        end
        else if (clr)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            lat_ok_reg <= 1'b0;
            lon_ok_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= launch.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            if (s3_v_reg && !s3_lon_reg)
                lat_ok_reg <= 1'b1;
            if (s3_v_reg && s3_lon_reg)
                lon_ok_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lon_reg   <= launch.is_lon;
        s1_int_reg   <= launch.int_part;
        s1_deg_reg   <= deg_prod[DIV100_SH +: 11];
        s1_fs_reg    <= fs_prod[FRAC_W-1:0];
        s2_lon_reg   <= s1_lon_reg;
        s2_mins_reg  <= mins_wide[6:0];
        s2_dege7_reg <= MAG_W'(s1_deg_reg) * DEG_SCALE;
        s2_fs_reg    <= s1_fs_reg;
        s3_lon_reg   <= s2_lon_reg;
        s3_u_reg     <= u_next;
        s3_dege7_reg <= s2_dege7_reg;
        if (s3_v_reg && !s3_lon_reg)
            lat_mag_reg <= mag_next;
        if (s3_v_reg && s3_lon_reg)
            lon_mag_reg <= mag_next;
    end

    assign result = {lat_ok_reg, lat_mag_reg, lon_ok_reg, lon_mag_reg};

endmodule

`default_nettype wire

// ===== hdl/ggap_line_parser.sv =====
// ============================================================================
// ggap_line_parser
// Byte-level sentence scanner, fix store and request bookkeeping.
// ============================================================================
`default_nettype none

module ggap_line_parser
    import ggap_pkg::*;
#(
    parameter int LINE_CAP    = 95,
    parameter int FRAC_DIGITS = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          is_req,
    input  wire logic [7:0]    c,
    input  wire coord_result_t coord,
    output coord_launch_t      launch,
    output logic               clr,
    output line_result_t       res
);

    localparam int CNT_W = $clog2(LINE_CAP + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAP);
    localparam logic [FD_W-1:0]  FD_MAX = FD_W'(FRAC_DIGITS);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              dead_reg, dead_next;
    logic [2:0]        hp_reg, hp_next;
    logic [3:0]        ti_reg, ti_next;
    logic              intok_reg, intok_next;
    logic [1:0]        phase_reg, phase_next;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [FD_W-1:0]   fd_reg, fd_next;
    logic [7:0]        qual_reg, qual_next;
    logic              latneg_reg, latneg_next;
    logic              lonneg_reg, lonneg_next;
    logic signed [COORD_W-1:0] stlat_reg, stlat_next;
    logic signed [COORD_W-1:0] stlon_reg, stlon_next;
    logic              fix_reg, fix_next;
    logic signed [COORD_W-1:0] rplat_reg, rplat_next;
    logic signed [COORD_W-1:0] rplon_reg, rplon_next;
    logic              rpfix_reg, rpfix_next;

    logic              is_digit;
    logic [3:0]        dval;
    logic [20:0]       int_mul;
    logic [11:0]       qual_mul;
    logic signed [COORD_W-1:0] pend_lat, pend_lon;
    logic              accept;

    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign dval     = 4'(c - CH_0);

    always_comb
    begin
        pend_lat = '0;
        pend_lon = '0;
        if (coord.lat_ok)
            pend_lat = latneg_reg ? -$signed({1'b0, coord.lat_mag})
                                  : $signed({1'b0, coord.lat_mag});
        if (coord.lon_ok)
            pend_lon = lonneg_reg ? -$signed({1'b0, coord.lon_mag})
                                  : $signed({1'b0, coord.lon_mag});
    end

    assign accept = (hp_reg == HDR_LEN) && (qual_reg != 8'd0) &&
                    ((ti_reg > TOK_QUAL) || ((ti_reg == TOK_QUAL) && intok_reg));

    always_comb
    begin
        cnt_next    = cnt_reg;
        dead_next   = dead_reg;
        hp_next     = hp_reg;
        ti_next     = ti_reg;
        intok_next  = intok_reg;
        phase_next  = phase_reg;
        int_next    = int_reg;
        frac_next   = frac_reg;
        fd_next     = fd_reg;
        qual_next   = qual_reg;
        latneg_next = latneg_reg;
        lonneg_next = lonneg_reg;
        stlat_next  = stlat_reg;
        stlon_next  = stlon_reg;
        fix_next    = fix_reg;
        rplat_next  = rplat_reg;
        rplon_next  = rplon_reg;
        rpfix_next  = rpfix_reg;
        int_mul     = '0;
        qual_mul    = '0;
        launch      = '0;
        clr         = 1'b0;
        res         = '0;
        launch.int_part    = int_reg;
        launch.frac_part   = frac_reg;
        launch.frac_digits = fd_reg;
        launch.is_lon      = (ti_reg == TOK_LON);

        if (is_req)
        begin
            res.valid  = 1'b1;
            res.kind   = RK_REQ;
            res.fresh  = fix_reg && (!rpfix_reg || (stlat_reg != rplat_reg) ||
                                     (stlon_reg != rplon_reg));
            rplat_next = stlat_reg;
            rplon_next = stlon_reg;
            rpfix_next = fix_reg;
        end
        else if (c == CH_LF)
        begin
            res.valid = 1'b1;
            res.kind  = RK_LINE;
            if (accept)
            begin
                stlat_next   = pend_lat;
                stlon_next   = pend_lon;
                fix_next     = 1'b1;
                res.accepted = 1'b1;
            end
            clr         = 1'b1;
            cnt_next    = '0;
            dead_next   = 1'b0;
            hp_next     = '0;
            ti_next     = '0;
            intok_next  = 1'b0;
            phase_next  = PH_INT;
            int_next    = '0;
            frac_next   = '0;
            fd_next     = '0;
            qual_next   = '0;
            latneg_next = 1'b0;
            lonneg_next = 1'b0;
        end
        else if ((c != CH_CR) && (cnt_reg < CAP))
        begin
            cnt_next = cnt_reg + 1'b1;
            if (!dead_reg)
            begin
                if (c == CH_NUL)
                    dead_next = 1'b1;
                else if ((hp_reg < HDR_LEN) && (c != hdr_char(hp_reg)))
                    dead_next = 1'b1;
                else
                begin
                    if (hp_reg < HDR_LEN)
                        hp_next = hp_reg + 1'b1;
                    if (c == CH_COMMA)
                    begin
                        if (intok_reg)
                        begin
                            launch.valid = (ti_reg == TOK_LAT) || (ti_reg == TOK_LON);
                            if (ti_reg < TOKEN_MAX)
                                ti_next = ti_reg + 1'b1;
                            intok_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // First character of a token restarts the number scan.
                        if (!intok_reg)
                        begin
                            intok_next = 1'b1;
                            phase_next = PH_INT;
                            int_next   = '0;
                            frac_next  = '0;
                            fd_next    = '0;
                            if (ti_reg == TOK_QUAL)
                                qual_next = '0;
                            if ((ti_reg == TOK_LAT_HEM) && (c == CH_S))
                                latneg_next = 1'b1;
                            if ((ti_reg == TOK_LON_HEM) && (c == CH_W))
                                lonneg_next = 1'b1;
                        end
                        if ((ti_reg == TOK_LAT) || (ti_reg == TOK_LON))
                        begin
                            if (phase_next == PH_INT)
                            begin
                                if (is_digit)
                                begin
                                    int_mul  = (21'(int_next) * 21'd10) + 21'(dval);
                                    int_next = (int_mul > 21'(INT_ACC_MAX)) ? INT_ACC_MAX
                                                                            : int_mul[INT_W-1:0];
                                end
                                else
                                    phase_next = (c == CH_DOT) ? PH_FRAC : PH_DONE;
                            end
                            else if (phase_next == PH_FRAC)
                            begin
                                if (!is_digit)
                                    phase_next = PH_DONE;
                                else if (fd_next < FD_MAX)
                                begin
                                    frac_next = FRAC_W'(frac_next * FRAC_W'(10))
                                              + FRAC_W'(dval);
                                    fd_next   = fd_next + 1'b1;
                                end
                            end
                        end
                        else if (ti_reg == TOK_QUAL)
                        begin
                            if (phase_next == PH_INT)
                            begin
                                if (is_digit)
                                begin
                                    qual_mul  = (12'(qual_next) * 12'd10) + 12'(dval);
                                    qual_next = (qual_mul > 12'(QUAL_MAX)) ? QUAL_MAX
                                                                           : qual_mul[7:0];
                                end
                                else
                                    phase_next = PH_DONE;
                            end
                        end
                    end
                end
            end
        end

        res.fix = fix_next;
        res.lat = stlat_next;
        res.lon = stlon_next;
        if (!step)
        begin
            launch.valid = 1'b0;
            clr          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            dead_reg   <= 1'b0;
            hp_reg     <= '0;
            ti_reg     <= '0;
            intok_reg  <= 1'b0;
            phase_reg  <= PH_INT;
            int_reg    <= '0;
            frac_reg   <= '0;
            fd_reg     <= '0;
            qual_reg   <= '0;
            latneg_reg <= 1'b0;
            lonneg_reg <= 1'b0;
            stlat_reg  <= '0;
            stlon_reg  <= '0;
            fix_reg    <= 1'b0;
            rplat_reg  <= '0;
            rplon_reg  <= '0;
            rpfix_reg  <= 1'b0;
        end
        else if (step)
        begin
            cnt_reg    <= cnt_next;
            dead_reg   <= dead_next;
            hp_reg     <= hp_next;
            ti_reg     <= ti_next;
            intok_reg  <= intok_next;
            phase_reg  <= phase_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            fd_reg     <= fd_next;
            qual_reg   <= qual_next;
            latneg_reg <= latneg_next;
            lonneg_reg <= lonneg_next;
            stlat_reg  <= stlat_next;
            stlon_reg  <= stlon_next;
            fix_reg    <= fix_next;
            rplat_reg  <= rplat_next;
            rplon_reg  <= rplon_next;
            rpfix_reg  <= rpfix_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nmea_gga_position_parser_unit.sv =====
// ============================================================================
// nmea_gga_position_parser_unit
// Streaming $GPGGA parser that keeps the last fixed position and answers
// measurement requests.
// ============================================================================
// The block takes one item per clock, a received byte or a measurement
// request, unless a result waits on a held output register. The result of
// an item, if any, enters the output register as the item leaves the input
// register, so an unblocked stream runs at one item per cycle. A line feed
// yields a line outcome and a request yields an answer; other bytes yield
// nothing. Coordinate conversion runs in a four-stage pipeline launched by
// the comma that closes the latitude or longitude field; a sentence needs
// at least three more bytes after that comma before its line feed, so the
// value is always ready when the fix is stored.
`default_nettype none

module nmea_gga_position_parser_unit
    import ggap_pkg::*;
#(
    parameter int LINE_CAP    = 95,
    parameter int FRAC_DIGITS = 5
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [0] sentence_accepted, [1] new_data,
                                        // [2] has_fix, [37:3] latitude,
                                        // [72:38] longitude, rest zero
    output logic             m_tuser    // [0] result_kind
);

    logic          in_v_reg;
    logic          in_req_reg;
    logic [7:0]    in_byte_reg;
    logic          out_v_reg;
    line_result_t  out_reg;
    logic          out_free;
    logic          step;
    coord_launch_t launch;
    coord_result_t coord;
    logic          clr;
    line_result_t  res;

    assign out_free = !out_v_reg || m_tready;
    assign step     = in_v_reg && (!res.valid || out_free);
    assign s_tready = !in_v_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_v_reg <= s_tvalid;
            if (step && res.valid)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (step && res.valid)
            out_reg <= res;
    end

    ggap_line_parser #(
        .LINE_CAP    (LINE_CAP),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .is_req (in_req_reg),
        .c      (in_byte_reg),
        .coord  (coord),
        .launch (launch),
        .clr    (clr),
        .res    (res)
    );

    ggap_coord_pipe #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_coord (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .clr    (clr),
        .result (coord)
    );

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.lon, out_reg.lat, out_reg.fix,
                       out_reg.fresh, out_reg.accepted};

endmodule

`default_nettype wire

// ===== hdl/ggap_checker.sv =====
// ============================================================================
// ggap_checker
// Port-level checks for the GGA position parser, bound to the top level.
// ============================================================================
`default_nettype none

`include "nmea_gga_position_parser_unit_assert.svh"

module ggap_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,
    input  wire logic        m_tuser
);

    // A waiting result must not change until it is taken.
    `GGAP_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // Request answers never claim an accepted sentence.
    `GGAP_ASSERT_IMP(a_req_no_accept, clk, rst_n, m_tvalid && m_tuser, !m_tdata[0])
    // Line outcomes never report fresh data.
    `GGAP_ASSERT_IMP(a_line_no_fresh, clk, rst_n, m_tvalid && !m_tuser, !m_tdata[1])
    // Fresh data and an accepted sentence both imply a stored fix.
    `GGAP_ASSERT_IMP(a_fix_implied, clk, rst_n, m_tvalid && (m_tdata[1] || m_tdata[0]), m_tdata[2])

endmodule

bind nmea_gga_position_parser_unit ggap_checker u_ggap_checker (.*);

`default_nettype wire
